[src/cih_pkg.sv]
// shared types and constants of the chained ip hash table
`default_nettype none
package cih_pkg;

    localparam int KEY_W       = 32;
    localparam int TABLE_SEL_W = 2;
    localparam int HANDLE_W    = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_MISS     = 3'd0,
        ST_HIT      = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HEAD,
        BK_WALK
    } bk_state_t;

    typedef struct packed {
        logic                   func;
        logic [TABLE_SEL_W-1:0] table_sel;
        logic [KEY_W-1:0]       ip_key;
    } req_word_t;

    typedef struct packed {
        status_t               status;
        logic [HANDLE_W-1:0]   node_handle;
    } rsp_word_t;

    typedef struct packed {
        logic             func;
        logic             tab_ok;
        logic [KEY_W-1:0] key;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } fr_status_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } bk_status_t;

endpackage
`default_nettype wire

[src/cih_stream_if.sv]
// valid/ready stream interface carrying one word
`default_nettype none
interface cih_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/cih_front.sv]
// request intake: table check, bucket address and a short job queue
`default_nettype none
module cih_front #(
    parameter int HASH_BITS  = 10,
    parameter int NUM_TABLES = 4
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    cih_stream_if.sink                           req,
    input  wire cih_pkg::bk_status_t             bk_stat,
    output cih_pkg::fr_status_t                  fr_stat,
    output logic [$clog2(NUM_TABLES << HASH_BITS)-1:0] fr_addr
);
    localparam int HEAD_DEPTH = NUM_TABLES << HASH_BITS;
    localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
    localparam int TAB_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int TSEL_W     = TAB_W + cih_pkg::TABLE_SEL_W;
    localparam int QD         = cih_pkg::QUEUE_DEPTH;
    localparam int PTR_W      = $clog2(QD);
    localparam int QCNT_W     = $clog2(QD + 1);

    cih_pkg::job_t      job_q_reg [QD];
    logic [HEAD_AW-1:0] addr_q_reg [QD];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    logic [TSEL_W-1:0]  tab_wide;
    logic               push;
    cih_pkg::job_t      new_job;
    logic [HEAD_AW-1:0] new_addr;

    assign tab_wide = TSEL_W'(req.data.table_sel);
    assign new_job.func   = req.data.func;
    assign new_job.tab_ok = tab_wide < TSEL_W'(NUM_TABLES);
    assign new_job.key    = req.data.ip_key;
    assign new_addr = HEAD_AW'({tab_wide, req.data.ip_key[HASH_BITS-1:0]});

    assign req.ready = (count_reg != QCNT_W'(QD)) && !bk_stat.clearing;
    assign push      = req.valid && req.ready;

    assign fr_stat.valid = count_reg != '0;
    assign fr_stat.job   = job_q_reg[rd_ptr_reg];
    assign fr_addr       = addr_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (bk_stat.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !bk_stat.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && bk_stat.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_q_reg[wr_ptr_reg]  <= new_job;
            addr_q_reg[wr_ptr_reg] <= new_addr;
        end
    end

endmodule
`default_nettype wire

[src/cih_back.sv]
// job execution: bucket heads, node pool, chain walk and insert
`default_nettype none
module cih_back #(
    parameter int HASH_BITS  = 10,
    parameter int NUM_TABLES = 4,
    parameter int POOL_DEPTH = 1024
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire cih_pkg::fr_status_t             fr_stat,
    input  wire [$clog2(NUM_TABLES << HASH_BITS)-1:0] fr_addr,
    output cih_pkg::bk_status_t                  bk_stat,
    cih_stream_if.source                         rsp
);
    localparam int HEAD_DEPTH = NUM_TABLES << HASH_BITS;
    localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int KEY_W      = cih_pkg::KEY_W;
    localparam int HEAD_W     = IDX_W + 1;
    localparam int NODE_W     = 1 + IDX_W + KEY_W;

    logic [HEAD_W-1:0]  head_mem [HEAD_DEPTH];
    logic [NODE_W-1:0]  node_mem [POOL_DEPTH];

    cih_pkg::bk_state_t state_reg, state_next;
    logic [HEAD_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]   nodes_used_reg, nodes_used_next;
    logic [IDX_W-1:0]   cur_idx_reg, cur_idx_next;
    logic               func_reg;
    logic               tab_ok_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [HEAD_AW-1:0] head_addr_reg;
    logic [HEAD_W-1:0]  head_rd_reg;
    logic [NODE_W-1:0]  node_rd_reg;
    logic               rsp_valid_reg;
    cih_pkg::rsp_word_t rsp_word_reg;

    logic               head_we, head_re, node_we, node_re;
    logic [HEAD_AW-1:0] head_wa, head_ra;
    logic [HEAD_W-1:0]  head_wd;
    logic [IDX_W-1:0]   node_wa, node_ra;
    logic [NODE_W-1:0]  node_wd;
    logic               pop, finish, absent, full;
    cih_pkg::status_t   res_status;
    logic [IDX_W-1:0]   res_idx;
    logic               hd_valid, nd_nvalid;
    logic [IDX_W-1:0]   hd_idx, nd_next, pool_top;
    logic [KEY_W-1:0]   nd_key;

    assign hd_valid  = head_rd_reg[IDX_W];
    assign hd_idx    = head_rd_reg[IDX_W-1:0];
    assign nd_key    = node_rd_reg[KEY_W-1:0];
    assign nd_next   = node_rd_reg[KEY_W +: IDX_W];
    assign nd_nvalid = node_rd_reg[KEY_W+IDX_W];
    assign full      = nodes_used_reg == CNT_W'(POOL_DEPTH);
    assign pool_top  = nodes_used_reg[IDX_W-1:0];

    assign bk_stat.clearing = state_reg == cih_pkg::BK_CLEAR;
    assign bk_stat.pop      = pop;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.data         = rsp_word_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        nodes_used_next = nodes_used_reg;
        cur_idx_next    = cur_idx_reg;
        head_we         = 1'b0;
        head_wa         = '0;
        head_wd         = '0;
        head_re         = 1'b0;
        head_ra         = '0;
        node_we         = 1'b0;
        node_wa         = '0;
        node_wd         = '0;
        node_re         = 1'b0;
        node_ra         = '0;
        pop             = 1'b0;
        finish          = 1'b0;
        absent          = 1'b0;
        res_status      = cih_pkg::ST_MISS;
        res_idx         = '0;
        case (state_reg)
            cih_pkg::BK_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = clr_cnt_reg;
                if (clr_cnt_reg == HEAD_AW'(HEAD_DEPTH - 1))
                begin
                    state_next = cih_pkg::BK_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            cih_pkg::BK_IDLE:
            begin
                if (fr_stat.valid && (!rsp_valid_reg || rsp.ready))
                begin
                    pop        = 1'b1;
                    head_re    = 1'b1;
                    head_ra    = fr_addr;
                    state_next = cih_pkg::BK_HEAD;
                end
            end
            cih_pkg::BK_HEAD:
            begin
                if (tab_ok_reg && hd_valid)
                begin
                    node_re      = 1'b1;
                    node_ra      = hd_idx;
                    cur_idx_next = hd_idx;
                    state_next   = cih_pkg::BK_WALK;
                end
                else if (tab_ok_reg)
                begin
                    absent = 1'b1;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            cih_pkg::BK_WALK:
            begin
                if (nd_key == key_reg)
                begin
                    finish     = 1'b1;
                    res_idx    = cur_idx_reg;
                    res_status = (func_reg == cih_pkg::FUNC_INSERT) ?
                                 cih_pkg::ST_PRESENT : cih_pkg::ST_HIT;
                end
                else if (nd_nvalid)
                begin
                    node_re      = 1'b1;
                    node_ra      = nd_next;
                    cur_idx_next = nd_next;
                end
                else
                begin
                    absent = 1'b1;
                end
            end
            default:
            begin
                state_next = cih_pkg::BK_IDLE;
            end
        endcase

        // key not in chain
        if (absent)
        begin
            finish = 1'b1;
            if (func_reg == cih_pkg::FUNC_INSERT)
            begin
                if (full)
                begin
                    res_status = cih_pkg::ST_FULL;
                end
                else
                begin
                    res_status      = cih_pkg::ST_INSERTED;
                    res_idx         = pool_top;
                    node_we         = 1'b1;
                    node_wa         = pool_top;
                    node_wd         = {hd_valid, hd_idx, key_reg};
                    head_we         = 1'b1;
                    head_wa         = head_addr_reg;
                    head_wd         = {1'b1, pool_top};
                    nodes_used_next = nodes_used_reg + 1'b1;
                end
            end
        end
        if (finish)
        begin
            state_next = cih_pkg::BK_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cih_pkg::BK_CLEAR;
            clr_cnt_reg    <= '0;
            nodes_used_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            nodes_used_reg <= nodes_used_next;
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg <= cur_idx_next;
        if (pop)
        begin
            func_reg      <= fr_stat.job.func;
            tab_ok_reg    <= fr_stat.job.tab_ok;
            key_reg       <= fr_stat.job.key;
            head_addr_reg <= fr_addr;
        end
        if (finish)
        begin
            rsp_word_reg.status      <= res_status;
            rsp_word_reg.node_handle <= cih_pkg::HANDLE_W'(res_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (head_re)
        begin
            head_rd_reg <= head_mem[head_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        if (node_re)
        begin
            node_rd_reg <= node_mem[node_ra];
        end
    end

endmodule
`default_nettype wire

[src/chained_ip_hash_table_core.sv]
// Chained IPv4 hash table: NUM_TABLES tables of 2**HASH_BITS buckets share one pool of
// POOL_DEPTH nodes; func selects lookup or insert-if-absent, and each request word returns
// one response word with a status and node handle. After reset the bucket heads are cleared
// one per cycle, all NUM_TABLES << HASH_BITS of them (4096 by default), during which no
// request is accepted. A request is then served by the registered head memory read followed
// by one node memory read per chain node visited, one link at a time; a two-word queue lets
// requests be taken while a response waits to be read.
`default_nettype none
module chained_ip_hash_table_core #(
    parameter int HASH_BITS  = 10,
    parameter int NUM_TABLES = 4,
    parameter int POOL_DEPTH = 1024
) (
    input  wire          clk,
    input  wire          rst_n,
    cih_stream_if.sink   req,
    cih_stream_if.source rsp
);
    localparam int HEAD_AW = $clog2(NUM_TABLES << HASH_BITS);

    cih_pkg::fr_status_t fr_stat;
    cih_pkg::bk_status_t bk_stat;
    logic [HEAD_AW-1:0]  fr_addr;

    cih_front #(
        .HASH_BITS  (HASH_BITS),
        .NUM_TABLES (NUM_TABLES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .bk_stat (bk_stat),
        .fr_stat (fr_stat),
        .fr_addr (fr_addr)
    );

    cih_back #(
        .HASH_BITS  (HASH_BITS),
        .NUM_TABLES (NUM_TABLES),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .fr_stat (fr_stat),
        .fr_addr (fr_addr),
        .bk_stat (bk_stat),
        .rsp     (rsp)
    );

    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> !bk_stat.clearing)
        else $error("request taken during head clear");

    a_no_rsp_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.clearing |-> !rsp.valid)
        else $error("response shown during head clear");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.pop |-> fr_stat.valid)
        else $error("job popped from empty queue");

    a_null_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.data.status == cih_pkg::ST_MISS ||
                      rsp.data.status == cih_pkg::ST_FULL) |-> rsp.data.node_handle == '0)
        else $error("nonzero handle on miss or full");

endmodule
`default_nettype wire

[verif/tb.sv]
// testbench for chained_ip_hash_table_core: predicts every response word and checks it in order
`timescale 1ns / 100ps
module tb;

    localparam int HASH_BITS   = 10;
    localparam int NUM_TABLES  = 4;
    localparam int POOL_DEPTH  = 1024;
    localparam int NUM_BUCKETS = 1 << HASH_BITS;
    localparam int HEAD_COUNT  = NUM_TABLES * NUM_BUCKETS;
    localparam int SETTLE      = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cih_stream_if #(.word_t(cih_pkg::req_word_t)) req ();
    cih_stream_if #(.word_t(cih_pkg::rsp_word_t)) rsp ();

    chained_ip_hash_table_core #(
        .HASH_BITS(HASH_BITS),
        .NUM_TABLES(NUM_TABLES),
        .POOL_DEPTH(POOL_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    always #5 clk = ~clk;

    // mirror of the table contents
    bit                        bucket_used [HEAD_COUNT];
    int unsigned               bucket_first [HEAD_COUNT];
    logic [cih_pkg::KEY_W-1:0] pool_key [POOL_DEPTH];
    int unsigned               pool_link [POOL_DEPTH];
    bit                        link_used [POOL_DEPTH];
    int unsigned               pool_fill;
    cih_pkg::req_word_t        stored_keys[$];

    cih_pkg::rsp_word_t        pending_rsp[$];
    int                        errors = 0;
    bit                        sender_idle = 1'b0;
    bit                        receiver_idle = 1'b0;
    int                        rsp_hold_req = 0;

    task automatic clear_table_model();
        for (int i = 0; i < HEAD_COUNT; i++)
        begin
            bucket_used[i] = 1'b0;
            bucket_first[i] = 0;
        end
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            pool_key[i] = '0;
            pool_link[i] = 0;
            link_used[i] = 1'b0;
        end
        pool_fill = 0;
        stored_keys.delete();
    endtask

    function automatic bit chain_find(int unsigned b, logic [cih_pkg::KEY_W-1:0] key,
                                      output int unsigned at);
        bit ok;
        int unsigned p;
        int unsigned steps;
        at = 0;
        ok = bucket_used[b];
        p = bucket_first[b];
        steps = 0;
        while (ok && steps < pool_fill)
        begin
            if (p >= POOL_DEPTH)
                return 1'b0;
            if (pool_key[p] == key)
            begin
                at = p;
                return 1'b1;
            end
            ok = link_used[p];
            p = pool_link[p];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic cih_pkg::rsp_word_t table_access(cih_pkg::req_word_t w);
        cih_pkg::rsp_word_t r;
        int unsigned b;
        int unsigned at;
        bit hit;
        r.status = cih_pkg::ST_MISS;
        r.node_handle = '0;
        if (int'(w.table_sel) < NUM_TABLES)
        begin
            b = int'(w.table_sel) * NUM_BUCKETS + (w.ip_key & (NUM_BUCKETS - 1));
            hit = chain_find(b, w.ip_key, at);
            if (w.func == cih_pkg::FUNC_LOOKUP)
            begin
                if (hit)
                begin
                    r.status = cih_pkg::ST_HIT;
                    r.node_handle = cih_pkg::HANDLE_W'(at);
                end
            end
            else if (hit)
            begin
                r.status = cih_pkg::ST_PRESENT;
                r.node_handle = cih_pkg::HANDLE_W'(at);
            end
            else if (pool_fill >= POOL_DEPTH)
                r.status = cih_pkg::ST_FULL;
            else
            begin
                pool_key[pool_fill] = w.ip_key;
                pool_link[pool_fill] = bucket_first[b];
                link_used[pool_fill] = bucket_used[b];
                bucket_first[b] = pool_fill;
                bucket_used[b] = 1'b1;
                r.status = cih_pkg::ST_INSERTED;
                r.node_handle = cih_pkg::HANDLE_W'(pool_fill);
                pool_fill++;
                stored_keys.push_back(w);
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [9:0] hot_low();
        case ($urandom_range(0, 3))
            0: return 10'h000;
            1: return 10'h3ff;
            2: return 10'h155;
            default: return 10'h2aa;
        endcase
    endfunction

    // stored_pct: share of known keys, hot_pct: share of colliding fresh keys
    function automatic cih_pkg::req_word_t pick_word(int insert_pct, int stored_pct,
                                                     int hot_pct);
        cih_pkg::req_word_t w;
        cih_pkg::req_word_t s;
        int r;
        w.func = ($urandom_range(0, 99) < insert_pct) ? cih_pkg::FUNC_INSERT :
                                                        cih_pkg::FUNC_LOOKUP;
        w.table_sel = cih_pkg::TABLE_SEL_W'($urandom_range(0,
                                             (1 << cih_pkg::TABLE_SEL_W) - 1));
        w.ip_key = $urandom();
        r = $urandom_range(0, 99);
        if (r < stored_pct && stored_keys.size() > 0)
        begin
            s = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            w.ip_key = s.ip_key;
            if ($urandom_range(0, 3) != 0)
                w.table_sel = s.table_sel;
        end
        else if (r < stored_pct + hot_pct)
            w.ip_key[9:0] = hot_low();
        return w;
    endfunction

    task automatic send_word(input cih_pkg::req_word_t w);
        int gap;
        gap = sender_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= w;
        @(negedge clk);
        while (!req.ready)
            @(negedge clk);
        @(posedge clk);
        pending_rsp.push_back(table_access(w));
    endtask

    task automatic send_op(input logic func, input int tab,
                           input logic [cih_pkg::KEY_W-1:0] key);
        cih_pkg::req_word_t w;
        w.func = func;
        w.table_sel = cih_pkg::TABLE_SEL_W'(tab);
        w.ip_key = key;
        send_word(w);
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void check_response(cih_pkg::rsp_word_t got);
        cih_pkg::rsp_word_t exp;
        if (pending_rsp.size() == 0)
        begin
            $error("unexpected word: status %0d node_handle %0d", got.status, got.node_handle);
            errors++;
            return;
        end
        exp = pending_rsp.pop_front();
        if (got.status !== exp.status)
        begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            errors++;
        end
        if (got.node_handle !== exp.node_handle)
        begin
            $error("node_handle: expected %0d, actual %0d", exp.node_handle, got.node_handle);
            errors++;
        end
    endfunction

    initial
    begin : rsp_side
        int hold;
        int stall;
        hold = 0;
        stall = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_req > 0)
            begin
                hold = rsp_hold_req;
                rsp_hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                rsp.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else if (receiver_idle && $urandom_range(0, 99) < 25)
            begin
                stall = gap_len();
                rsp.ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
            else
                rsp.ready <= 1'b1;
            @(negedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                check_response(rsp.data);
        end
    end

    // empty tables, chains, head and tail of a chain, same key in other tables, extreme keys
    task automatic test_directed();
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        send_op(cih_pkg::FUNC_LOOKUP, 0, 32'h0000_0000);
        send_op(cih_pkg::FUNC_INSERT, 0, 32'h0000_0000);
        send_op(cih_pkg::FUNC_LOOKUP, 0, 32'h0000_0000);
        send_op(cih_pkg::FUNC_INSERT, 0, 32'h0000_0000);
        send_op(cih_pkg::FUNC_LOOKUP, 1, 32'h0000_0000);
        send_op(cih_pkg::FUNC_INSERT, 3, 32'hffff_ffff);
        send_op(cih_pkg::FUNC_INSERT, 3, 32'h0000_03ff);
        send_op(cih_pkg::FUNC_LOOKUP, 3, 32'hffff_ffff);
        send_op(cih_pkg::FUNC_LOOKUP, 3, 32'h0000_03ff);
        send_op(cih_pkg::FUNC_INSERT, 3, 32'hffff_ffff);
        send_op(cih_pkg::FUNC_LOOKUP, 3, 32'h7fff_ffff);
        send_op(cih_pkg::FUNC_INSERT, 0, 32'h0000_0400);
        send_op(cih_pkg::FUNC_INSERT, 0, 32'hffff_fc00);
        send_op(cih_pkg::FUNC_LOOKUP, 0, 32'h0000_0000);
        send_op(cih_pkg::FUNC_LOOKUP, 0, 32'h0000_0800);
        send_op(cih_pkg::FUNC_INSERT, 1, 32'hffff_fc00);
        send_op(cih_pkg::FUNC_LOOKUP, 1, 32'hffff_fc00);
        send_op(cih_pkg::FUNC_INSERT, 2, 32'ha5a5_a5a5);
        send_op(cih_pkg::FUNC_INSERT, 2, 32'h5a5a_5a5a);
        send_op(cih_pkg::FUNC_LOOKUP, 2, 32'ha5a5_a5a5);
        send_op(cih_pkg::FUNC_LOOKUP, 2, 32'h5a5a_5a5a);
        send_op(cih_pkg::FUNC_LOOKUP, 1, 32'ha5a5_a5a5);
        wait_idle();
    endtask

    task automatic test_mixed(input int count);
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        for (int i = 0; i < count; i++)
            send_word(pick_word(75, 35, 35));
        wait_idle();
    endtask

    // responses held back long enough that the queue fills and requests stall
    task automatic test_backpressure();
        sender_idle = 1'b0;
        receiver_idle = 1'b1;
        rsp_hold_req = 300;
        for (int i = 0; i < 40; i++)
            send_word(pick_word(70, 35, 30));
        wait_idle();
    endtask

    task automatic test_pool_fill();
        int guard;
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        guard = 0;
        while (pool_fill < POOL_DEPTH && guard < 2000)
        begin
            send_word(pick_word(95, 5, 15));
            guard++;
        end
        wait_idle();
    endtask

    // full pool: absent keys are refused, known keys still found
    task automatic test_pool_full();
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        for (int i = 0; i < 60; i++)
            send_word(pick_word(60, 50, 20));
        wait_idle();
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.data = '0;
        clear_table_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mixed(200);
        test_backpressure();
        test_pool_fill();
        test_pool_full();
        if (errors == 0)
            $display("chained_ip_hash_table_core regression: pass");
        else
            $display("chained_ip_hash_table_core regression: fail");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("chained_ip_hash_table_core regression: fail");
        $finish;
    end

endmodule

[chained_ip_hash_table_core.f]
src/cih_pkg.sv
src/cih_stream_if.sv
src/cih_front.sv
src/cih_back.sv
src/chained_ip_hash_table_core.sv
verif/tb.sv
